### hw/rtl/rv64ex_pkg.sv
// ----------------------------------------------------------------------------
// rv64ex_pkg
// Shared types and constants for the RV64I OP-IMM / ADD execute core.
// ----------------------------------------------------------------------------
package rv64ex_pkg;

  localparam int unsigned XLEN      = 64;
  localparam int unsigned NUM_REGS  = 32;
  localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);
  localparam int unsigned INSN_W    = 32;

  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;

  localparam logic [5:0] FUNCT6_SRL = 6'h00;
  localparam logic [5:0] FUNCT6_SRA = 6'h10;
  localparam logic [6:0] FUNCT7_ADD = 7'h00;

  localparam logic [XLEN-1:0] PC_STEP = 64'd4;

  typedef logic [XLEN-1:0]      xword_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  typedef enum logic [2:0] {
    F3_ADD  = 3'd0,
    F3_SLL  = 3'd1,
    F3_SLT  = 3'd2,
    F3_SLTU = 3'd3,
    F3_XOR  = 3'd4,
    F3_SR   = 3'd5,
    F3_OR   = 3'd6,
    F3_AND  = 3'd7
  } funct3_t;

endpackage

### hw/rtl/rv64_integer_execute_subset_core.sv
// ----------------------------------------------------------------------------
// rv64_integer_execute_subset_core
// Executes RV64I OP-IMM instructions and ADD against a 32 x 64 register file.
//
// One instruction per clock when the result side keeps up. An accepted
// instruction reads rs1/rs2 from the register file memory (synchronous read)
// into the read registers, executes from them and, once the output register
// is free, lands in it; the register file write happens on that same edge.
// A write and the next instruction's read of the same entry meet at the same
// edge, so the most recent write is kept in a bypass register and overrides
// stale read data. x0 reads zero, the write to it is dropped and its result
// shows as zero. Encodings outside the subset (loads, stores, SUB, bad shift
// funct bits, any other opcode) come out with illegal set, index and value
// zero, next_pc the unchanged PC, and no state change. After reset the
// register file reads all zero through per-entry valid bits; no clearing pass
// is needed. A cfg transfer loads the PC; it is meant to be issued only while
// the core is idle.
// ----------------------------------------------------------------------------
module rv64_integer_execute_subset_core
  import rv64ex_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [XLEN-1:0]   cfg_start_address,

  input  logic              in_valid,
  output logic              in_ready,
  input  logic [INSN_W-1:0] in_instruction,

  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_illegal,
  output logic [4:0]        out_dest_index,
  output logic [XLEN-1:0]   out_dest_value,
  output logic [XLEN-1:0]   out_next_pc
);

  // Register file memory and its per-entry valid bits (reset = all zero)
  xword_t                rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0]   rf_vld_r;

  // Read stage outputs, captured at the input transfer
  xword_t                rd1_r;
  xword_t                rd2_r;
  logic                  rv1_r;
  logic                  rv2_r;

  // Execute stage
  logic                  ex_vld_r;
  logic [INSN_W-1:0]     insn_r;

  // Bypass of the latest register file write
  logic                  fwd_vld_r;
  reg_idx_t              fwd_idx_r;
  xword_t                fwd_val_r;

  // Program counter
  xword_t                pc_r;

  // Output register
  logic                  out_vld_r;
  logic                  out_ill_r;
  reg_idx_t              out_idx_r;
  xword_t                out_val_r;
  xword_t                out_pc_r;

  logic                  in_acc;
  logic                  cfg_acc;
  logic                  ex_adv;

  // Decode of the instruction in execute
  logic [6:0]            opc;
  reg_idx_t              rd_idx;
  reg_idx_t              rs1_idx;
  reg_idx_t              rs2_idx;
  funct3_t               f3;
  logic [5:0]            f6;
  logic [6:0]            f7;
  logic [5:0]            shamt;
  xword_t                imm;
  xword_t                src_a;
  xword_t                src_b;
  xword_t                alu_res;
  logic                  ex_ok;
  logic                  rf_we;
  xword_t                res_shown;

  reg_idx_t              in_rs1;
  reg_idx_t              in_rs2;

  // ---------------------------------------------------------------- handshake
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;

  // Execute drains into the output register when it is empty or being taken
  assign ex_adv   = ex_vld_r & (~out_vld_r | out_ready);
  assign in_ready = ~ex_vld_r | ex_adv;
  assign in_acc   = in_valid & in_ready;

  assign in_rs1 = in_instruction[19:15];
  assign in_rs2 = in_instruction[24:20];

  // ---------------------------------------------------------------- decode
  assign opc     = insn_r[6:0];
  assign rd_idx  = insn_r[11:7];
  assign f3      = funct3_t'(insn_r[14:12]);
  assign rs1_idx = insn_r[19:15];
  assign rs2_idx = insn_r[24:20];
  assign f6      = insn_r[31:26];
  assign f7      = insn_r[31:25];
  assign shamt   = insn_r[25:20];
  assign imm     = {{(XLEN-12){insn_r[31]}}, insn_r[31:20]};

  // Operand select: x0, then bypass, then memory (unwritten entries read 0)
  always_comb begin
    if (rs1_idx == '0) begin
      src_a = '0;
    end else if (fwd_vld_r && (fwd_idx_r == rs1_idx)) begin
      src_a = fwd_val_r;
    end else if (rv1_r) begin
      src_a = rd1_r;
    end else begin
      src_a = '0;
    end

    if (rs2_idx == '0) begin
      src_b = '0;
    end else if (fwd_vld_r && (fwd_idx_r == rs2_idx)) begin
      src_b = fwd_val_r;
    end else if (rv2_r) begin
      src_b = rd2_r;
    end else begin
      src_b = '0;
    end
  end

  // ---------------------------------------------------------------- ALU
  always_comb begin
    alu_res = '0;
    ex_ok   = 1'b1;
    if (opc == OPC_OP_IMM) begin
      case (f3)
        F3_ADD:  alu_res = src_a + imm;
        F3_SLL: begin
          if (f6 != FUNCT6_SRL) begin
            ex_ok = 1'b0;
          end else begin
            alu_res = src_a << shamt;
          end
        end
        F3_SLT:  alu_res = {{(XLEN-1){1'b0}}, ($signed(src_a) < $signed(imm))};
        F3_SLTU: alu_res = {{(XLEN-1){1'b0}}, (src_a < imm)};
        F3_XOR:  alu_res = src_a ^ imm;
        F3_SR: begin
          if (f6 == FUNCT6_SRL) begin
            alu_res = src_a >> shamt;
          end else if (f6 == FUNCT6_SRA) begin
            alu_res = xword_t'($signed(src_a) >>> shamt);
          end else begin
            ex_ok = 1'b0;
          end
        end
        F3_OR:   alu_res = src_a | imm;
        F3_AND:  alu_res = src_a & imm;
        default: ex_ok = 1'b0;
      endcase
    end else if ((opc == OPC_OP) && (f3 == F3_ADD) && (f7 == FUNCT7_ADD)) begin
      alu_res = src_a + src_b;
    end else begin
      ex_ok = 1'b0;
    end
  end

  assign rf_we     = ex_adv & ex_ok & (rd_idx != '0);
  assign res_shown = (ex_ok && (rd_idx != '0)) ? alu_res : '0;

  // ---------------------------------------------------------------- memory
  // One write port (retire), two read ports (issue); read data registered.
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[rd_idx] <= alu_res;
    end
    if (in_acc) begin
      rd1_r <= rf_mem[in_rs1];
      rd2_r <= rf_mem[in_rs2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
      rv1_r    <= 1'b0;
      rv2_r    <= 1'b0;
    end else begin
      if (rf_we) begin
        rf_vld_r[rd_idx] <= 1'b1;
      end
      if (in_acc) begin
        rv1_r <= rf_vld_r[in_rs1];
        rv2_r <= rf_vld_r[in_rs2];
      end
    end
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      fwd_vld_r <= 1'b0;
      pc_r      <= '0;
    end else begin
      if (in_acc) begin
        ex_vld_r <= 1'b1;
      end else if (ex_adv) begin
        ex_vld_r <= 1'b0;
      end

      if (ex_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end

      if (rf_we) begin
        fwd_vld_r <= 1'b1;
      end

      // cfg wins over retire; the user is to issue cfg only while idle, the core does not enforce it
      if (cfg_acc) begin
        pc_r <= cfg_start_address;
      end else if (ex_adv && ex_ok) begin
        pc_r <= pc_r + PC_STEP;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      insn_r <= in_instruction;
    end
    if (rf_we) begin
      fwd_idx_r <= rd_idx;
      fwd_val_r <= alu_res;
    end
    if (ex_adv) begin
      out_ill_r <= ~ex_ok;
      out_idx_r <= ex_ok ? rd_idx : '0;
      out_val_r <= res_shown;
      out_pc_r  <= ex_ok ? (pc_r + PC_STEP) : pc_r;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_illegal    = out_ill_r;
  assign out_dest_index = out_idx_r;
  assign out_dest_value = out_val_r;
  assign out_next_pc    = out_pc_r;

  // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
  a_ill_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_ill_r) |-> ((out_idx_r == '0) && (out_val_r == '0)))
    else $error("illegal result with nonzero index or value");

  a_x0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_idx_r == '0)) |-> (out_val_r == '0))
    else $error("x0 result shown nonzero");

  a_pc_step: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_adv && ex_ok && !cfg_acc) |=> (pc_r == $past(pc_r) + PC_STEP))
    else $error("pc did not advance by 4 on a legal retire");

  a_ill_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_adv && !ex_ok && !cfg_acc) |=> $stable(pc_r))
    else $error("pc changed on an illegal instruction");

  a_fwd_not_x0: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_vld_r |-> (fwd_idx_r != '0))
    else $error("bypass register holds a write to x0");
`endif

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for the RV64I OP-IMM / ADD execute core. Directed instructions
// hit immediate and shift extremes, every funct3, x0 as destination, the
// rejected encodings and PC wrap. Random instruction streams then run under
// four idle/stall mixes with a new start address between mixes. A built-in
// executor tracks the register file and PC and predicts every result.
// ----------------------------------------------------------------------------
module tb_top;
  import rv64ex_pkg::*;

  // opcodes and funct codes the core must reject or that the package lacks
  localparam logic [6:0] OPC_LOAD    = 7'h03;
  localparam logic [6:0] OPC_STORE   = 7'h23;
  localparam logic [6:0] FUNCT7_SUB  = 7'h20;
  localparam logic [5:0] FUNCT6_SLL  = 6'h00;
  localparam logic [5:0] FUNCT6_BAD  = 6'h01;
  localparam logic [5:0] FUNCT6_BAD2 = 6'h30;

  localparam int unsigned CORE_LATENCY = 4;    // extra idle wait after the pipe drains
  localparam int unsigned STALL_LIMIT  = 5000; // cycles with no transfer
  localparam int unsigned PHASE_ITEMS  = 340;

  typedef struct packed {
    logic     illegal;
    reg_idx_t dest_index;
    xword_t   dest_value;
    xword_t   next_pc;
  } writeback_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  xword_t            cfg_start_address = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [INSN_W-1:0] in_instruction = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_illegal;
  logic [4:0]        out_dest_index;
  xword_t            out_dest_value;
  xword_t            out_next_pc;

  // shadow architectural state
  xword_t arch_regs [NUM_REGS];
  xword_t arch_pc;

  writeback_t expected_writebacks[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;

  rv64_integer_execute_subset_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_start_address (cfg_start_address),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_instruction    (in_instruction),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_illegal       (out_illegal),
    .out_dest_index    (out_dest_index),
    .out_dest_value    (out_dest_value),
    .out_next_pc       (out_next_pc)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Executor: applies one instruction to the shadow state, returns what the
  // core should show for it.
  // ---------------------------------------------------------------------------
  function automatic xword_t read_arch(input reg_idx_t idx);
    return (idx == '0) ? '0 : arch_regs[idx];
  endfunction

  function automatic writeback_t execute_insn(input logic [INSN_W-1:0] insn);
    logic [6:0] opc;
    reg_idx_t   rd;
    funct3_t    f3;
    logic [5:0] f6;
    logic [6:0] f7;
    logic [5:0] shamt;
    xword_t     rs1_val;
    xword_t     imm;
    xword_t     res;
    logic       legal;
    writeback_t wb;
    opc     = insn[6:0];
    rd      = insn[11:7];
    f3      = funct3_t'(insn[14:12]);
    f6      = insn[31:26];
    f7      = insn[31:25];
    shamt   = insn[25:20];
    rs1_val = read_arch(insn[19:15]);
    imm     = {{(XLEN-12){insn[31]}}, insn[31:20]};
    res     = '0;
    legal   = 1'b1;
    if (opc == OPC_OP_IMM) begin
      case (f3)
        F3_ADD:  res = rs1_val + imm;
        F3_SLL: begin
          if (f6 != FUNCT6_SLL) legal = 1'b0;
          else res = rs1_val << shamt;
        end
        F3_SLT:  res = ($signed(rs1_val) < $signed(imm)) ? 64'd1 : 64'd0;
        F3_SLTU: res = (rs1_val < imm) ? 64'd1 : 64'd0;
        F3_XOR:  res = rs1_val ^ imm;
        F3_SR: begin
          if (f6 == FUNCT6_SRL) res = rs1_val >> shamt;
          else if (f6 == FUNCT6_SRA) res = xword_t'($signed(rs1_val) >>> shamt);
          else legal = 1'b0;
        end
        F3_OR:   res = rs1_val | imm;
        default: res = rs1_val & imm;
      endcase
    end else if (opc == OPC_OP && f3 == F3_ADD && f7 == FUNCT7_ADD) begin
      res = rs1_val + read_arch(insn[24:20]);
    end else begin
      legal = 1'b0;
    end

    if (!legal) begin
      wb = '{illegal: 1'b1, dest_index: '0, dest_value: '0, next_pc: arch_pc};
    end else begin
      if (rd == '0) res = '0;
      else arch_regs[rd] = res;
      arch_pc = arch_pc + PC_STEP;
      wb = '{illegal: 1'b0, dest_index: rd, dest_value: res, next_pc: arch_pc};
    end
    return wb;
  endfunction

  // ---------------------------------------------------------------------------
  // Encoders
  // ---------------------------------------------------------------------------
  function automatic logic [INSN_W-1:0] i_type(input logic [6:0] opc,
      input logic [2:0] f3, input reg_idx_t rd, input reg_idx_t rs1,
      input logic [11:0] imm);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [INSN_W-1:0] r_type(input logic [6:0] f7,
      input logic [2:0] f3, input reg_idx_t rd, input reg_idx_t rs1,
      input reg_idx_t rs2);
    return {f7, rs2, rs1, f3, rd, OPC_OP};
  endfunction

  // half the picks are drawn from x0..x4 so back-to-back dependencies are common
  function automatic reg_idx_t pick_reg();
    return ($urandom_range(1) == 0) ? reg_idx_t'($urandom_range(4))
                                    : reg_idx_t'($urandom_range(NUM_REGS - 1));
  endfunction

  function automatic logic [INSN_W-1:0] random_insn();
    logic [2:0]  f3;
    logic [5:0]  f6;
    logic [11:0] imm;
    f3  = 3'($urandom_range(7));
    imm = 12'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        // shifts mostly carry a valid funct6; SRA on the left shift is rejected
        if (f3 == F3_SLL || f3 == F3_SR) begin
          f6  = ($urandom_range(2) == 0) ? FUNCT6_SRA : FUNCT6_SRL;
          imm = {f6, 6'($urandom)};
        end
        return i_type(OPC_OP_IMM, f3, pick_reg(), pick_reg(), imm);
      end
      6, 7:    return r_type(FUNCT7_ADD, F3_ADD, pick_reg(), pick_reg(), pick_reg());
      8: begin
        // broken: junk funct fields on either group
        if ($urandom_range(1) == 0)
          return r_type(7'($urandom), f3, pick_reg(), pick_reg(), pick_reg());
        return i_type(OPC_OP_IMM, ($urandom_range(1) == 0) ? F3_SLL : F3_SR,
                      pick_reg(), pick_reg(), 12'($urandom));
      end
      default: return INSN_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus primitives; all entered and left at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_insn(input logic [INSN_W-1:0] insn);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_instruction <= insn;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_writebacks.push_back(execute_insn(insn));
    @(negedge clk);
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle_core(input int unsigned extra_cycles);
    in_valid <= 1'b0;
    while (expected_writebacks.size() != 0) @(negedge clk);
    repeat (extra_cycles) @(negedge clk);
  endtask

  task automatic load_start_address(input xword_t addr);
    settle_core(CORE_LATENCY);
    cfg_valid         <= 1'b1;
    cfg_start_address <= addr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    arch_pc = addr;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // every funct3, immediate and shift extremes, x0 as source and destination
  task automatic test_alu_ops();
    send_insn(i_type(OPC_OP_IMM, F3_ADD, 5'd1, 5'd0, 12'h7ff));
    send_insn(i_type(OPC_OP_IMM, F3_ADD, 5'd2, 5'd0, 12'h800));
    send_insn(i_type(OPC_OP_IMM, F3_ADD, 5'd3, 5'd0, 12'hfff));
    send_insn(r_type(FUNCT7_ADD, F3_ADD, 5'd4, 5'd1, 5'd2));
    send_insn(i_type(OPC_OP_IMM, F3_SLL, 5'd5, 5'd3, {FUNCT6_SLL, 6'd63}));
    send_insn(i_type(OPC_OP_IMM, F3_SR,  5'd6, 5'd5, {FUNCT6_SRL, 6'd63}));
    send_insn(i_type(OPC_OP_IMM, F3_SR,  5'd7, 5'd5, {FUNCT6_SRA, 6'd63}));
    send_insn(i_type(OPC_OP_IMM, F3_SR,  5'd8, 5'd5, {FUNCT6_SRA, 6'd0}));
    send_insn(i_type(OPC_OP_IMM, F3_SLT, 5'd9, 5'd2, 12'h000));
    send_insn(i_type(OPC_OP_IMM, F3_SLTU, 5'd10, 5'd1, 12'hfff));
    send_insn(i_type(OPC_OP_IMM, F3_XOR, 5'd12, 5'd3, 12'h555));
    send_insn(i_type(OPC_OP_IMM, F3_OR,  5'd13, 5'd0, 12'h800));
    send_insn(i_type(OPC_OP_IMM, F3_AND, 5'd14, 5'd3, 12'h7ff));
    send_insn(i_type(OPC_OP_IMM, F3_ADD, 5'd0, 5'd3, 12'h001));
    send_insn(r_type(FUNCT7_ADD, F3_ADD, 5'd15, 5'd5, 5'd5));
  endtask

  // rejected encodings must leave registers and PC alone
  task automatic test_illegal_encodings();
    send_insn(i_type(OPC_LOAD, F3_SLTU, 5'd1, 5'd2, 12'h010));
    send_insn(i_type(OPC_STORE, F3_SLTU, 5'd1, 5'd2, 12'h010));
    send_insn(r_type(FUNCT7_SUB, F3_ADD, 5'd1, 5'd3, 5'd3));
    send_insn(r_type(FUNCT7_ADD, F3_SLL, 5'd1, 5'd3, 5'd3));
    send_insn(i_type(OPC_OP_IMM, F3_SLL, 5'd1, 5'd3, {FUNCT6_BAD, 6'd1}));
    send_insn(i_type(OPC_OP_IMM, F3_SR,  5'd1, 5'd3, {FUNCT6_BAD2, 6'd1}));
    send_insn('1);
    send_insn('0);
    send_insn(r_type(FUNCT7_ADD, F3_ADD, 5'd16, 5'd1, 5'd0));
  endtask

  // PC near the top of the address space wraps through zero
  task automatic test_pc_wrap();
    load_start_address(64'hFFFF_FFFF_FFFF_FFF8);
    send_insn(i_type(OPC_OP_IMM, F3_ADD, 5'd17, 5'd17, 12'h001));
    send_insn(i_type(OPC_OP_IMM, F3_ADD, 5'd17, 5'd17, 12'h001));
    send_insn(i_type(OPC_OP_IMM, F3_ADD, 5'd17, 5'd17, 12'h001));
  endtask

  task automatic test_random_stream(input int unsigned idle_pct,
      input int unsigned stall_pct, input xword_t start_addr,
      input logic pause_midway);
    load_start_address(start_addr);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
      // hold off until the pipe is empty, then resume back to back
      if (pause_midway && n == PHASE_ITEMS / 2) settle_core(0);
      send_insn(random_insn());
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input xword_t got,
      input xword_t want);
    $display("%0t ns: %s mismatch: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    writeback_t want_wb;
    if (rst_n && out_valid && out_ready) begin
      if (expected_writebacks.size() == 0) begin
        report_mismatch("unexpected result, next_pc", out_next_pc, '0);
      end else begin
        want_wb = expected_writebacks.pop_front();
        if (out_illegal !== want_wb.illegal)
          report_mismatch("illegal", xword_t'(out_illegal), xword_t'(want_wb.illegal));
        if (out_dest_index !== want_wb.dest_index)
          report_mismatch("dest_index", xword_t'(out_dest_index),
                          xword_t'(want_wb.dest_index));
        if (out_dest_value !== want_wb.dest_value)
          report_mismatch("dest_value", out_dest_value, want_wb.dest_value);
        if (out_next_pc !== want_wb.next_pc)
          report_mismatch("next_pc", out_next_pc, want_wb.next_pc);
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog: too long without any transfer on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("rv64_integer_execute_subset_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < NUM_REGS; i++) arch_regs[i] = '0;
    arch_pc = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_alu_ops();
    test_illegal_encodings();
    test_pc_wrap();
    test_random_stream(0,  0,  64'($urandom) << 2 | 64'($urandom) << 34, 1'b1);
    test_random_stream(77, 0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    test_random_stream(0,  77, 64'h0, 1'b0);
    test_random_stream(27, 27, {32'($urandom), 32'($urandom)}, 1'b0);

    settle_core(2 * CORE_LATENCY);
    if (mismatches == 0) begin
      $display("rv64_integer_execute_subset_core regression: pass");
    end else begin
      $display("rv64_integer_execute_subset_core regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/rv64ex_pkg.sv
hw/rtl/rv64_integer_execute_subset_core.sv
verif/tb_top.sv
